>>> rtl/bffrp_pkg.sv
// Shared types and constants of the bitmap first-fit rectangle packer.
`timescale 1ns / 1ps
`default_nettype none

package bffrp_pkg;

    localparam int DIM_W    = 7;
    localparam int STATUS_W = 2;
    localparam int SIDX_W   = 2;
    localparam int POS_W    = 6;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;
    localparam int STEP_W   = 3;

    localparam logic [STATUS_W-1:0] STATUS_PLACED   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_BIG  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd2;

    localparam logic CFG_SURFACE_WIDTH  = 1'b0;
    localparam logic CFG_SURFACE_HEIGHT = 1'b1;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [POS_W-1:0] pos;
    } t_run_stat;

endpackage

`default_nettype wire

>>> rtl/bffrp_run_find.sv
// Bit-serial search for the first run of free columns of a given length in one row.
`timescale 1ns / 1ps
`default_nettype none

module bffrp_run_find #(
    parameter int WIDTH = 64
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_start,
    input  wire [WIDTH-1:0]                 i_free,
    input  wire [bffrp_pkg::DIM_W-1:0]      i_len,
    output bffrp_pkg::t_run_stat            o_stat
);

    localparam logic [bffrp_pkg::STEP_W-1:0] LAST_STEP =
        bffrp_pkg::STEP_W'(bffrp_pkg::DIM_W - 1);

    logic                            r_busy;
    logic                            r_done;
    logic [bffrp_pkg::STEP_W-1:0]    r_k;
    logic [WIDTH-1:0]                r_p;
    logic [WIDTH-1:0]                r_acc;
    logic [bffrp_pkg::DIM_W-1:0]     r_off;
    logic [bffrp_pkg::DIM_W-1:0]     w_piece;
    logic [bffrp_pkg::POS_W-1:0]     w_pos;

    assign w_piece = bffrp_pkg::DIM_W'(1) << r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= r_busy && (r_k == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                if (r_k == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
                r_k <= r_k + 1'b1;
            end
        end
    end

    // acc[x] ends as the AND of free[x .. x+len-1]; p holds runs of 2^k
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p   <= i_free;
            r_acc <= '1;
            r_off <= '0;
        end else if (r_busy) begin
            if (i_len[r_k]) begin
                r_acc <= r_acc & (r_p >> r_off);
                r_off <= r_off + w_piece;
            end
            r_p <= r_p & (r_p >> w_piece);
        end
    end

    always_comb begin
        w_pos = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (r_acc[i]) begin
                w_pos = bffrp_pkg::POS_W'(i);
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.found = |r_acc;
    assign o_stat.pos   = w_pos;

endmodule

`default_nettype wire

>>> rtl/bitmap_first_fit_rect_packer.sv
// Top level of the bitmap first-fit rectangle packer.
//
// Input channel i_s_axis_*: one item is a request {req_height, req_width}.
// Output channel o_m_axis_*: one item per request {top_pos, left_pos,
// surface_index, status}. Config port i_cfg_*: index 0 surface width,
// index 1 surface height; write only while the block is idle.
// One request is in work at a time; o_s_axis_tready is high when idle.
// Steps per request, through the row memory and the run search:
//   refused: the request goes straight to S_OUT, which loads the output register
//   per surface visited: the S_SURF state; per candidate row y on an open
//   surface: its h rows from y are read and ORed, then the run search runs
//   opening a new surface: every row is written (clear and mark in one sweep)
//   marking a found place: the h rows are read and written back with the span
//   set, then the output register is loaded
// A finished result waits in the output register while the next request
// is accepted and worked on; a new result is held back only while the
// previous one is still not taken.
// Reset empties the output register and marks every surface unused; a
// surface's bitmap is cleared when it is opened, so no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_first_fit_rect_packer #(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_SURFACES = 4
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire                            i_cfg_addr,
    input  wire [bffrp_pkg::DIM_W-1:0]     i_cfg_wdata,
    input  wire                            i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [6:0] req_width, [13:7] req_height, [15:14] zero
    input  wire [bffrp_pkg::IN_W-1:0]      i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  wire                            i_m_axis_tready,
    // [1:0] status, [3:2] surface_index, [9:4] left_pos, [15:10] top_pos
    output logic [bffrp_pkg::OUT_W-1:0]    o_m_axis_tdata
);

    localparam int DEPTH = MAX_SURFACES * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (MAX_SURFACES > 1) ? $clog2(MAX_SURFACES) : 1;
    localparam int UW    = $clog2(MAX_SURFACES + 1);
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = bffrp_pkg::POS_W;
    localparam int DW    = bffrp_pkg::DIM_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SURF = 7'b0000010,
        S_OPEN = 7'b0000100,
        S_READ = 7'b0001000,
        S_RUN  = 7'b0010000,
        S_MARK = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                 r_state, n_state;
    logic [DW-1:0]          r_cfg_w, r_cfg_h;
    logic [DW-1:0]          r_w, r_h, r_sw, r_sh;
    logic [SW-1:0]          r_s;
    logic [UW-1:0]          r_used;
    logic [YW-1:0]          r_y;
    logic [XW-1:0]          r_x;
    logic [RW-1:0]          r_rcnt;
    logic                   r_pend;
    logic [MAX_WIDTH-1:0]   r_q;
    logic [MAX_WIDTH-1:0]   r_occ;
    logic [AW-1:0]          r_wa;
    logic [bffrp_pkg::STATUS_W-1:0] r_status;
    logic                   r_m_valid;
    logic [bffrp_pkg::OUT_W-1:0] r_m_data;
    logic                   r_start;
    logic [MAX_WIDTH-1:0]   r_free;

    logic [MAX_WIDTH-1:0]   mem [DEPTH];

    logic [DW-1:0]          w_in_w, w_in_h, w_cl_w, w_cl_h;
    logic                   w_accept;
    logic                   w_more;
    logic                   w_rd_en;
    logic [AW-1:0]          w_base, w_rd_addr, w_open_addr;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [MAX_WIDTH-1:0]   w_wdata;
    logic [MAX_WIDTH-1:0]   w_lowmask, w_span, w_colmask;
    logic                   w_out_load;
    logic                   w_open_last;
    bffrp_pkg::t_run_stat   w_run;

    assign w_in_w   = i_s_axis_tdata[DW-1:0];
    assign w_in_h   = i_s_axis_tdata[2*DW-1:DW];
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_cl_w = DW'(1);
        end else if (int'(r_cfg_w) > MAX_WIDTH) begin
            w_cl_w = DW'(MAX_WIDTH);
        end else begin
            w_cl_w = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            w_cl_h = DW'(1);
        end else if (int'(r_cfg_h) > MAX_HEIGHT) begin
            w_cl_h = DW'(MAX_HEIGHT);
        end else begin
            w_cl_h = r_cfg_h;
        end
    end

    assign w_base      = AW'(AW'(r_s) * AW'(MAX_HEIGHT));
    assign w_rd_addr   = w_base + AW'(r_y) + AW'(r_rcnt);
    assign w_open_addr = w_base + AW'(r_rcnt);
    assign w_more      = r_rcnt < RW'(r_h);
    assign w_rd_en     = ((r_state == S_READ) || (r_state == S_MARK)) && w_more;
    assign w_open_last = r_rcnt == RW'(MAX_HEIGHT - 1);

    assign w_lowmask = {MAX_WIDTH{1'b1}} >> (DW'(MAX_WIDTH) - r_w);
    assign w_span    = w_lowmask << r_x;
    assign w_colmask = {MAX_WIDTH{1'b1}} >> (DW'(MAX_WIDTH) - r_sw);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wa;
        w_wdata = r_q | w_span;
        case (r_state)
            S_OPEN: begin
                w_we    = 1'b1;
                w_waddr = w_open_addr;
                w_wdata = (r_rcnt < RW'(r_h)) ? w_lowmask : '0;
            end
            S_MARK: begin
                w_we = r_pend;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_q  <= mem[w_rd_addr];
            r_wa <= w_rd_addr;
        end
    end

    bffrp_run_find #(
        .WIDTH (MAX_WIDTH)
    ) u_run_find (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_free  (r_free),
        .i_len   (r_w),
        .o_stat  (w_run)
    );

    assign w_out_load = (r_state == S_OUT) && (!r_m_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = ((w_in_w > w_cl_w) || (w_in_h > w_cl_h)) ? S_OUT : S_SURF;
                end
            end
            S_SURF: begin
                n_state = (UW'(r_s) >= r_used) ? S_OPEN : S_READ;
            end
            S_OPEN: begin
                if (w_open_last) begin
                    n_state = S_OUT;
                end
            end
            S_READ: begin
                if (!w_more && !r_pend) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_run.done) begin
                    if (w_run.found) begin
                        n_state = S_MARK;
                    end else if (int'(r_y) + 1 + int'(r_h) <= int'(r_sh)) begin
                        n_state = S_READ;
                    end else if (int'(r_s) == MAX_SURFACES - 1) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SURF;
                    end
                end
            end
            S_MARK: begin
                if (!w_more && !r_pend) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg_w   <= DW'(64);
            r_cfg_h   <= DW'(64);
            r_used    <= '0;
            r_pend    <= 1'b0;
            r_start   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= w_rd_en;
            r_start <= (r_state == S_READ) && !w_more && !r_pend;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bffrp_pkg::CFG_SURFACE_WIDTH:  r_cfg_w <= i_cfg_wdata;
                    bffrp_pkg::CFG_SURFACE_HEIGHT: r_cfg_h <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_SURF) && (UW'(r_s) >= r_used)) begin
                r_used <= UW'(r_s) + 1'b1;
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_w      <= w_in_w;
                r_h      <= w_in_h;
                r_sw     <= w_cl_w;
                r_sh     <= w_cl_h;
                r_s      <= '0;
                r_status <= ((w_in_w > w_cl_w) || (w_in_h > w_cl_h)) ?
                            bffrp_pkg::STATUS_TOO_BIG : bffrp_pkg::STATUS_PLACED;
            end
            S_SURF: begin
                r_y    <= '0;
                r_x    <= '0;
                r_rcnt <= '0;
                r_occ  <= '0;
            end
            S_OPEN: begin
                r_rcnt <= r_rcnt + 1'b1;
            end
            S_READ: begin
                if (w_rd_en) begin
                    r_rcnt <= r_rcnt + 1'b1;
                end
                if (r_pend) begin
                    r_occ <= r_occ | r_q;
                end
                r_free <= ~r_occ & w_colmask;
            end
            S_RUN: begin
                r_rcnt <= '0;
                r_occ  <= '0;
                if (w_run.done) begin
                    if (w_run.found) begin
                        r_x <= w_run.pos;
                    end else if (int'(r_y) + 1 + int'(r_h) <= int'(r_sh)) begin
                        r_y <= r_y + 1'b1;
                    end else if (int'(r_s) == MAX_SURFACES - 1) begin
                        r_status <= bffrp_pkg::STATUS_NO_SPACE;
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
            end
            S_MARK: begin
                if (w_rd_en) begin
                    r_rcnt <= r_rcnt + 1'b1;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    if (r_status == bffrp_pkg::STATUS_PLACED) begin
                        r_m_data <= {bffrp_pkg::POS_W'(r_y), r_x,
                                     bffrp_pkg::SIDX_W'(r_s), r_status};
                    end else begin
                        r_m_data <= {{(bffrp_pkg::OUT_W - bffrp_pkg::STATUS_W){1'b0}},
                                     r_status};
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/bffrp_checker.sv
// Port-level checks of the rectangle packer and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bffrp_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_s_axis_tvalid,
    input wire                            o_s_axis_tready,
    input wire                            o_m_axis_tvalid,
    input wire                            i_m_axis_tready,
    input wire [bffrp_pkg::OUT_W-1:0]     o_m_axis_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output item present after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] == bffrp_pkg::STATUS_PLACED ||
                             o_m_axis_tdata[1:0] == bffrp_pkg::STATUS_TOO_BIG ||
                             o_m_axis_tdata[1:0] == bffrp_pkg::STATUS_NO_SPACE))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[1:0] != bffrp_pkg::STATUS_PLACED)
        |-> (o_m_axis_tdata[bffrp_pkg::OUT_W-1:2] == '0))
        else $error("refused item carries a position");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second item taken while one is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled output item changed");

endmodule

bind bitmap_first_fit_rect_packer bffrp_checker u_bffrp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
